[rtl/dlbf_pkg.sv]
// dlbf_pkg: shared types and constants for the dual light-strip breath/fade controller.
// No dependencies.
`default_nettype none
package dlbf_pkg;

   localparam int LEVEL_BITS = 12;
   localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

   // command codes
   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_ON         = 3'd1;
   localparam logic [2:0] CMD_OFF        = 3'd2;
   localparam logic [2:0] CMD_TOGGLE     = 3'd3;
   localparam logic [2:0] CMD_BREATH_ON  = 3'd4;
   localparam logic [2:0] CMD_BREATH_OFF = 3'd5;

   // door codes
   localparam logic [1:0] DOOR_STOPPED = 2'd0;
   localparam logic [1:0] DOOR_OPENING = 2'd1;
   localparam logic [1:0] DOOR_CLOSING = 2'd2;
   localparam logic [1:0] DOOR_UNKNOWN = 2'd3;

   // register indexes
   localparam logic [2:0] REG_USER_LEVEL      = 3'd0;
   localparam logic [2:0] REG_AUTO_OFF_MS     = 3'd1;
   localparam logic [2:0] REG_LEVEL_DECREMENT = 3'd2;
   localparam logic [2:0] REG_FADE_INTERVAL   = 3'd3;
   localparam logic [2:0] REG_BREATH_INTERVAL = 3'd4;
   localparam logic [2:0] REG_PHASE_STEP      = 3'd5;
   localparam logic [2:0] REG_OUTPUT_INVERTED = 3'd6;

   // Q16 breathing factor: 0.2 + 0.8 * (sin + 1) / 2
   localparam logic [16:0] FACTOR_OFFSET = 17'd13107;
   localparam logic [16:0] FACTOR_SCALE  = 17'd52429;   // also ceil(2^18 / 5)
   localparam logic [15:0] HALF_TURN     = 16'h8000;

   typedef struct packed {
      logic [LEVEL_BITS-1:0] user_level;
      logic [31:0]           auto_off_ms;
      logic [LEVEL_BITS-1:0] level_decrement;
      logic [15:0]           fade_interval_ms;
      logic [15:0]           breath_interval_ms;
      logic [15:0]           breath_phase_step;
      logic                  output_inverted;
   } cfg_type;

   typedef struct packed {
      logic                  lit;
      logic                  fading;
      logic                  breath_enabled;
      logic [LEVEL_BITS-1:0] fade_level;
      logic [15:0]           breath_phase;
   } light_type;

endpackage
`default_nettype wire

[rtl/dlbf_sine_rom.sv]
// dlbf_sine_rom: sine table lookup, returns sin + 1 in Q15 (1..65535) for a 16-bit phase.
// Table built at elaboration; depends on nothing else.
`default_nettype none
module dlbf_sine_rom #(
   parameter int ENTRIES = 256
) (
   input  wire logic [15:0] phase,
   output logic      [15:0] sine_biased
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

   function automatic logic [15:0] quarter_sine(input int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      logic [63:0] r;
      x = (64'(j) * TWO_PI_Q30) / 64'(ENTRIES);
      x2 = (x * x) >> 30;
      term = x;
      sum = $signed(x);
      for (int k = 1; k <= 7; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if ((k % 2) == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      if (sum < 0) sum = 0;
      r = (64'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      return r[15:0];
   endfunction

   function automatic logic [15:0] rom_entry(input int unsigned i);
      int unsigned j;
      logic neg;
      logic [15:0] v;
      neg = (i >= ENTRIES / 2);
      j = neg ? i - ENTRIES / 2 : i;
      if (j > ENTRIES / 4) j = ENTRIES / 2 - j;
      v = quarter_sine(j);
      return neg ? 16'h8000 - v : 16'h8000 + v;
   endfunction

   logic [15:0]      rom [ENTRIES];
   logic [16+CW-1:0] idx_prod;
   logic [IW-1:0]    idx;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_rom
      assign rom[g] = rom_entry(g);
   end

   assign idx_prod    = (16 + CW)'(phase) * (16 + CW)'(ENTRIES);
   assign idx         = idx_prod[16 +: IW];
   assign sine_biased = rom[idx];

endmodule
`default_nettype wire

[rtl/dlbf_mult.sv]
// dlbf_mult: the shared 17x17 unsigned multiplier used for the controller's base, factor and level products.
// No dependencies.
`default_nettype none
module dlbf_mult (
   input  wire logic [16:0] op_a,
   input  wire logic [16:0] op_b,
   output logic      [33:0] product
);
   assign product = 34'(op_a) * 34'(op_b);
endmodule
`default_nettype wire

[rtl/dlbf_state.sv]
// dlbf_state: light state registers and the per-request update (commands, tick, fade, auto-off).
// Depends on dlbf_pkg.
`default_nettype none
module dlbf_state (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 update,
   input  wire logic [2:0]           command,
   input  wire logic [1:0]           door,
   input  wire logic [31:0]          now_ms,
   input  wire dlbf_pkg::cfg_type    cfg,
   output dlbf_pkg::light_type       light
);

   logic                            lit_ff, lit_in;
   logic                            fading_ff, fading_in;
   logic                            armed_ff, armed_in;
   logic                            breath_ff, breath_in;
   logic [dlbf_pkg::LEVEL_BITS-1:0] level_ff, level_in;
   logic [31:0]                     last_fade_ff, last_fade_in;
   logic [31:0]                     start_ff, start_in;
   logic [15:0]                     phase_ff, phase_in;
   logic [31:0]                     last_breath_ff, last_breath_in;
   logic [1:0]                      door_ff, door_in;
   logic [31:0]                     breath_age, fade_age;

   assign breath_age = now_ms - last_breath_ff;
   assign fade_age   = now_ms - last_fade_ff;

   always_comb begin
      lit_in         = lit_ff;
      fading_in      = fading_ff;
      armed_in       = armed_ff;
      breath_in      = breath_ff;
      level_in       = level_ff;
      last_fade_in   = last_fade_ff;
      start_in       = start_ff;
      phase_in       = phase_ff;
      last_breath_in = last_breath_ff;
      door_in        = door_ff;
      case (command)
         dlbf_pkg::CMD_TICK: begin
            if (lit_ff && !fading_ff && breath_age >= 32'(cfg.breath_interval_ms)) begin
               last_breath_in = now_ms;
               phase_in       = phase_ff + cfg.breath_phase_step;
            end
            if (fading_ff && fade_age >= 32'(cfg.fade_interval_ms)) begin
               last_fade_in = now_ms;
               level_in = (level_ff > cfg.level_decrement) ?
                          level_ff - cfg.level_decrement : '0;
               if (level_in == '0) begin
                  lit_in    = 1'b0;
                  fading_in = 1'b0;
                  armed_in  = 1'b0;
               end
            end
            if (door != door_ff) begin
               lit_in    = 1'b1;
               fading_in = 1'b0;
               if (door != dlbf_pkg::DOOR_STOPPED) begin
                  armed_in  = 1'b0;
                  breath_in = 1'b0;
               end else begin
                  level_in = cfg.user_level;
                  armed_in = 1'b1;
                  start_in = now_ms;
               end
               door_in = door;
            end
            if (armed_in && !fading_in && lit_in && door == dlbf_pkg::DOOR_STOPPED &&
                (now_ms - start_in) >= cfg.auto_off_ms) begin
               lit_in       = 1'b1;
               fading_in    = 1'b1;
               level_in     = cfg.user_level;
               last_fade_in = now_ms;
               armed_in     = 1'b0;
            end
         end
         dlbf_pkg::CMD_ON: begin
            fading_in = 1'b0;
            lit_in    = 1'b1;
            level_in  = cfg.user_level;
            armed_in  = 1'b0;
         end
         dlbf_pkg::CMD_OFF: begin
            lit_in       = 1'b1;
            fading_in    = 1'b1;
            level_in     = cfg.user_level;
            last_fade_in = now_ms;
            armed_in     = 1'b0;
         end
         dlbf_pkg::CMD_TOGGLE: begin
            lit_in    = 1'b1;
            fading_in = lit_ff && !fading_ff;
            level_in  = cfg.user_level;
            armed_in  = 1'b0;
            if (lit_ff && !fading_ff) last_fade_in = now_ms;
         end
         dlbf_pkg::CMD_BREATH_ON: begin
            breath_in = 1'b1;
            if (!lit_ff) begin
               lit_in    = 1'b1;
               fading_in = 1'b0;
            end
         end
         dlbf_pkg::CMD_BREATH_OFF: begin
            breath_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff         <= 1'b0;
         fading_ff      <= 1'b0;
         armed_ff       <= 1'b0;
         breath_ff      <= 1'b0;
         level_ff       <= '0;
         last_fade_ff   <= '0;
         start_ff       <= '0;
         phase_ff       <= '0;
         last_breath_ff <= '0;
         door_ff        <= dlbf_pkg::DOOR_STOPPED;
      end else if (update) begin
         lit_ff         <= lit_in;
         fading_ff      <= fading_in;
         armed_ff       <= armed_in;
         breath_ff      <= breath_in;
         level_ff       <= level_in;
         last_fade_ff   <= last_fade_in;
         start_ff       <= start_in;
         phase_ff       <= phase_in;
         last_breath_ff <= last_breath_in;
         door_ff        <= door_in;
      end
   end

   assign light.lit            = lit_ff;
   assign light.fading         = fading_ff;
   assign light.breath_enabled = breath_ff;
   assign light.fade_level     = level_ff;
   assign light.breath_phase   = phase_ff;

endmodule
`default_nettype wire

[rtl/dual_led_breath_fade_controller.sv]
// Dual light-strip controller: breathing, antiphase motion display and fade-out.
// rsp_valid is registered and rises as the sequencer leaves ST_L2 with the response loaded.
// Requests do not overlap: req_stall is high outside ST_IDLE, as each request uses the one
// shared 17x17 multiplier in turn (moving base, then factor and level per strip).
// Reset (synchronous, active high) clears the light state and loads register defaults.
// Depends on dlbf_pkg, dlbf_state, dlbf_sine_rom, dlbf_mult.
`default_nettype none
module dual_led_breath_fade_controller #(
   parameter int SINE_ENTRIES = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic [1:0]  req_door_state,
   input  wire logic [31:0] req_now_ms,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [11:0]      rsp_strip_one_duty,
   output logic [11:0]      rsp_strip_two_duty,
   output logic             rsp_light_lit,
   output logic             rsp_fade_active,
   output logic             rsp_breath_requested,
   // register write port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int LB = dlbf_pkg::LEVEL_BITS;

   // one-hot sequencer
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_BASE = 6'b000010,   // base = 2 * user / 5 (moving display)
      ST_F1   = 6'b000100,   // strip one factor
      ST_L1   = 6'b001000,   // strip one level
      ST_F2   = 6'b010000,   // strip two factor
      ST_L2   = 6'b100000    // strip two level, load response once the output is free
   } state_type;

   state_type           state_ff, state_in;
   dlbf_pkg::cfg_type   cfg_ff;
   dlbf_pkg::light_type light;

   logic          accept;
   logic          rsp_valid_ff;
   logic          rsp_load;
   logic [1:0]    door_norm;
   logic          moving_ff;
   logic [LB-1:0] base_ff;
   logic [15:0]   factor_ff;
   logic [LB-1:0] lvl1_ff;
   logic [15:0]   phase_sel;
   logic [15:0]   sine_biased;
   logic [16:0]   op_a, op_b;
   logic [33:0]   product;
   logic [16:0]   factor_sum;
   logic [LB-1:0] lvl_new;
   logic [LB-1:0] duty1, duty2;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // response register is free when empty or being taken this cycle
   assign rsp_load  = (state_ff == ST_L2) && (!rsp_valid_ff || !rsp_stall);

   // an undefined door code counts as stopped
   assign door_norm = (req_door_state == dlbf_pkg::DOOR_UNKNOWN) ?
                      dlbf_pkg::DOOR_STOPPED : req_door_state;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.user_level         <= LB'(4095);
         cfg_ff.auto_off_ms        <= 32'd15000;
         cfg_ff.level_decrement    <= LB'(20);
         cfg_ff.fade_interval_ms   <= 16'd30;
         cfg_ff.breath_interval_ms <= 16'd30;
         cfg_ff.breath_phase_step  <= 16'd983;
         cfg_ff.output_inverted    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dlbf_pkg::REG_USER_LEVEL:      cfg_ff.user_level <= csr_data[LB-1:0];
            dlbf_pkg::REG_AUTO_OFF_MS:     cfg_ff.auto_off_ms <= csr_data;
            dlbf_pkg::REG_LEVEL_DECREMENT: cfg_ff.level_decrement <= csr_data[LB-1:0];
            dlbf_pkg::REG_FADE_INTERVAL:   cfg_ff.fade_interval_ms <= csr_data[15:0];
            dlbf_pkg::REG_BREATH_INTERVAL: cfg_ff.breath_interval_ms <= csr_data[15:0];
            dlbf_pkg::REG_PHASE_STEP:      cfg_ff.breath_phase_step <= csr_data[15:0];
            dlbf_pkg::REG_OUTPUT_INVERTED: cfg_ff.output_inverted <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   dlbf_state u_state (
      .clock   (clock),
      .reset   (reset),
      .update  (accept),
      .command (req_command),
      .door    (door_norm),
      .now_ms  (req_now_ms),
      .cfg     (cfg_ff),
      .light   (light)
   );

   // strip two runs half a turn behind strip one
   assign phase_sel = state_ff[4] || state_ff[5] ?
                      light.breath_phase + dlbf_pkg::HALF_TURN : light.breath_phase;

   dlbf_sine_rom #(.ENTRIES(SINE_ENTRIES)) u_rom (
      .phase       (phase_sel),
      .sine_biased (sine_biased)
   );

   // operand select for the shared multiplier
   always_comb begin
      op_a = dlbf_pkg::FACTOR_SCALE;
      op_b = 17'({cfg_ff.user_level, 1'b0});
      case (state_ff)
         ST_BASE: op_b = 17'({cfg_ff.user_level, 1'b0});
         ST_F1, ST_F2: op_b = {1'b0, sine_biased};
         ST_L1, ST_L2: begin
            op_a = 17'(base_ff);
            op_b = {1'b0, factor_ff};
         end
         default: begin
         end
      endcase
   end

   dlbf_mult u_mult (
      .op_a    (op_a),
      .op_b    (op_b),
      .product (product)
   );

   assign factor_sum = dlbf_pkg::FACTOR_OFFSET + 17'(product[31:16]);
   // level product >> 16, capped at full scale
   assign lvl_new = (product[33:16] > 18'(dlbf_pkg::LEVEL_MAX)) ?
                    dlbf_pkg::LEVEL_MAX : product[16 +: LB];

   // final duty selection, then output polarity
   always_comb begin
      duty1 = '0;
      duty2 = '0;
      if (light.lit) begin
         if (light.fading) begin
            duty1 = light.fade_level;
            duty2 = light.fade_level;
         end else if (moving_ff || light.breath_enabled) begin
            duty1 = lvl1_ff;
            duty2 = lvl_new;
         end else begin
            duty1 = cfg_ff.user_level;
            duty2 = cfg_ff.user_level;
         end
      end
      if (cfg_ff.output_inverted) begin
         duty1 = dlbf_pkg::LEVEL_MAX - duty1;
         duty2 = dlbf_pkg::LEVEL_MAX - duty2;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_BASE;
         ST_BASE: state_in = ST_F1;
         ST_F1:   state_in = ST_L1;
         ST_L1:   state_in = ST_F2;
         ST_F2:   state_in = ST_L2;
         ST_L2:   if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // response valid: set on load, cleared when taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (rsp_load) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) moving_ff <= (door_norm != dlbf_pkg::DOOR_STOPPED);
      case (state_ff)
         ST_BASE: base_ff <= moving_ff ? product[18 +: LB] : cfg_ff.user_level;
         ST_F1, ST_F2: factor_ff <= factor_sum[15:0];
         ST_L1: lvl1_ff <= lvl_new;
         ST_L2: if (rsp_load) begin
            rsp_strip_one_duty   <= duty1;
            rsp_strip_two_duty   <= duty2;
            rsp_light_lit        <= light.lit;
            rsp_fade_active      <= light.fading;
            rsp_breath_requested <= light.breath_enabled;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire
